// File: rtl/core/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

  // Field and datapath widths
  localparam int QUAT_W     = 16;
  localparam int BIN_W      = 5;
  localparam int PROD_W     = 2 * QUAT_W;
  localparam int ARG_W      = 34;
  localparam int CW         = 37;
  localparam int ANG_W      = 34;
  localparam int S_W        = 32;
  localparam int ITERS      = 28;
  localparam int CORDIC_LAT = ITERS + 2;
  localparam int SQ_IN_W    = 62;
  localparam int RT_W       = 31;
  localparam int REM_W      = 32;
  localparam int SQRT_LAT   = 31;

  // Command queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QLVL_W  = 3;

  // Bin count
  localparam int BINS_DEFAULT = 18;
  localparam int BINS_MAX_W   = 7;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t ANG_HALF     = ang_t'(64'sd2147483648);
  localparam ang_t ANG_QUARTER  = ang_t'(64'sd1073741824);
  localparam ang_t ANG_LIM_FULL = ang_t'(64'sd2147483647);
  localparam ang_t ANG_LIM_HALF = ang_t'(64'sd1073741823);

  localparam logic signed [ARG_W-1:0] ONE_ARG = ARG_W'(64'sd1073741824);
  localparam logic signed [S_W-1:0]   ONE_S   = S_W'(64'sd1073741824);

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } q2e_quat_t;

  typedef struct packed {
    logic [BIN_W-1:0] roll_bin;
    logic [BIN_W-1:0] pitch_bin;
    logic [BIN_W-1:0] yaw_bin;
  } q2e_result_t;

  typedef struct packed {
    logic signed [ARG_W-1:0] roll_y;
    logic signed [ARG_W-1:0] roll_x;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic signed [S_W-1:0]   pitch_s;
    logic                    pitch_full;
  } q2e_cmd_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q2e_qstat_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic ang_t atan_turn(input int i);
    ang_t r;
    begin
      case (i)
        0:  r = ang_t'(64'sd536870912);
        1:  r = ang_t'(64'sd316933406);
        2:  r = ang_t'(64'sd167458907);
        3:  r = ang_t'(64'sd85004756);
        4:  r = ang_t'(64'sd42667331);
        5:  r = ang_t'(64'sd21354465);
        6:  r = ang_t'(64'sd10680862);
        7:  r = ang_t'(64'sd5340245);
        8:  r = ang_t'(64'sd2670163);
        9:  r = ang_t'(64'sd1335087);
        10: r = ang_t'(64'sd667544);
        11: r = ang_t'(64'sd333772);
        12: r = ang_t'(64'sd166886);
        13: r = ang_t'(64'sd83443);
        14: r = ang_t'(64'sd41722);
        15: r = ang_t'(64'sd20861);
        16: r = ang_t'(64'sd10430);
        17: r = ang_t'(64'sd5215);
        18: r = ang_t'(64'sd2608);
        19: r = ang_t'(64'sd1304);
        20: r = ang_t'(64'sd652);
        21: r = ang_t'(64'sd326);
        22: r = ang_t'(64'sd163);
        23: r = ang_t'(64'sd81);
        24: r = ang_t'(64'sd41);
        25: r = ang_t'(64'sd20);
        26: r = ang_t'(64'sd10);
        27: r = ang_t'(64'sd5);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/q2e_front.sv
`default_nettype none
module q2e_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire q2e_pkg::q2e_quat_t   quat_i,
  output logic                      push_o,
  output q2e_pkg::q2e_cmd_t         cmd_o
);
  import q2e_pkg::*;

  logic                     valid_q;
  logic signed [PROD_W-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [PROD_W-1:0] p_wz_q, p_xy_q, p_wy_q, p_zx_q;
  logic signed [ARG_W-1:0]  d_raw;

  // Track the item in the product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Form all component products
  always_ff @(posedge clk_i) begin
    p_wx_q <= quat_i.quat_w * quat_i.quat_x;
    p_yz_q <= quat_i.quat_y * quat_i.quat_z;
    p_xx_q <= quat_i.quat_x * quat_i.quat_x;
    p_yy_q <= quat_i.quat_y * quat_i.quat_y;
    p_zz_q <= quat_i.quat_z * quat_i.quat_z;
    p_wz_q <= quat_i.quat_w * quat_i.quat_z;
    p_xy_q <= quat_i.quat_x * quat_i.quat_y;
    p_wy_q <= quat_i.quat_w * quat_i.quat_y;
    p_zx_q <= quat_i.quat_z * quat_i.quat_x;
  end

  // Build atan2 arguments and classify the asin argument
  always_comb begin
    cmd_o.roll_y = (ARG_W'(p_wx_q) + ARG_W'(p_yz_q)) <<< 1;
    cmd_o.roll_x = ONE_ARG - ((ARG_W'(p_xx_q) + ARG_W'(p_yy_q)) <<< 1);
    cmd_o.yaw_y  = (ARG_W'(p_wz_q) + ARG_W'(p_xy_q)) <<< 1;
    cmd_o.yaw_x  = ONE_ARG - ((ARG_W'(p_yy_q) + ARG_W'(p_zz_q)) <<< 1);
    d_raw        = (ARG_W'(p_wy_q) - ARG_W'(p_zx_q)) <<< 1;
    cmd_o.pitch_full = (d_raw >= ONE_ARG) || (d_raw <= -ONE_ARG);
    priority if (d_raw >= ONE_ARG) begin
      cmd_o.pitch_s = ONE_S;
    end else if (d_raw <= -ONE_ARG) begin
      cmd_o.pitch_s = -ONE_S;
    end else begin
      cmd_o.pitch_s = S_W'(d_raw);
    end
  end

  assign push_o = valid_q;

endmodule
`default_nettype wire

// File: rtl/core/q2e_queue.sv
`default_nettype none
module q2e_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire q2e_pkg::q2e_cmd_t    data_i,
  input  wire logic                 pop_i,
  output q2e_pkg::q2e_cmd_t         data_o,
  output q2e_pkg::q2e_qstat_t       stat_o
);
  import q2e_pkg::*;

  q2e_cmd_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLVL_W-1:0] level_q;

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   level_q <= level_q + QLVL_W'(1);
        2'b01:   level_q <= level_q - QLVL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (level_q == '0);
  assign stat_o.level = level_q;

endmodule
`default_nettype wire

// File: rtl/core/q2e_isqrt.sv
`default_nettype none
module q2e_isqrt (
  input  wire logic                         clk_i,
  input  wire logic [q2e_pkg::SQ_IN_W-1:0]  v_i,
  output logic [q2e_pkg::RT_W-1:0]          root_o
);
  import q2e_pkg::*;

  logic [REM_W-1:0]   rem_q  [SQRT_LAT];
  logic [RT_W-1:0]    root_q [SQRT_LAT];
  logic [SQ_IN_W-1:0] val_q  [SQRT_LAT];

  // One result bit per stage, two radicand bits in
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
    logic [REM_W-1:0]   cur_rem;
    logic [RT_W-1:0]    cur_root;
    logic [SQ_IN_W-1:0] cur_val;
    logic [REM_W+1:0]   r2, t, diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_val  = v_i;
    end else begin : g_next
      assign cur_rem  = rem_q[k-1];
      assign cur_root = root_q[k-1];
      assign cur_val  = val_q[k-1];
    end

    assign r2   = {cur_rem, cur_val[SQ_IN_W-1-2*k -: 2]};
    assign t    = (REM_W+2)'({cur_root, 2'b01});
    assign ge   = (r2 >= t);
    assign diff = r2 - t;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
      root_q[k] <= {cur_root[RT_W-2:0], ge};
      val_q[k]  <= cur_val;
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule
`default_nettype wire

// File: rtl/core/q2e_cordic.sv
`default_nettype none
module q2e_cordic #(
  parameter q2e_pkg::ang_t LIM = q2e_pkg::ANG_LIM_FULL
) (
  input  wire logic                              clk_i,
  input  wire logic signed [q2e_pkg::ARG_W-1:0]  y_i,
  input  wire logic signed [q2e_pkg::ARG_W-1:0]  x_i,
  output q2e_pkg::ang_t                          ang_o
);
  import q2e_pkg::*;

  logic signed [CW-1:0] x_q     [ITERS+1];
  logic signed [CW-1:0] y_q     [ITERS+1];
  ang_t                 acc_q   [ITERS+1];
  logic                 spec_q  [ITERS+1];
  ang_t                 spang_q [ITERS+1];
  ang_t                 ang_q;
  logic                 neg;

  assign neg = (x_i < 0);

  // Fold into the right half plane and catch axis cases
  always_ff @(posedge clk_i) begin
    x_q[0]    <= neg ? -CW'(x_i) : CW'(x_i);
    y_q[0]    <= neg ? -CW'(y_i) : CW'(y_i);
    acc_q[0]  <= neg ? ((y_i > 0) ? ANG_HALF : -ANG_HALF) : '0;
    spec_q[0] <= (y_i == 0) || (x_i == 0);
    if (y_i == 0) begin
      spang_q[0] <= neg ? ANG_HALF : '0;
    end else begin
      spang_q[0] <= (y_i > 0) ? ANG_QUARTER : -ANG_QUARTER;
    end
  end

  // Rotate towards the x axis, one micro-rotation per stage
  for (genvar i = 0; i < ITERS; i++) begin : g_it
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (y_q[i] > 0) begin
        x_q[i+1]   <= x_q[i] + dx;
        y_q[i+1]   <= y_q[i] - dy;
        acc_q[i+1] <= acc_q[i] + atan_turn(i);
      end else begin
        x_q[i+1]   <= x_q[i] - dx;
        y_q[i+1]   <= y_q[i] + dy;
        acc_q[i+1] <= acc_q[i] - atan_turn(i);
      end
      spec_q[i+1]  <= spec_q[i];
      spang_q[i+1] <= spang_q[i];
    end
  end

  // Clamp overshoot; axis cases pass exact
  always_ff @(posedge clk_i) begin
    priority if (spec_q[ITERS]) begin
      ang_q <= spang_q[ITERS];
    end else if (acc_q[ITERS] > LIM) begin
      ang_q <= LIM;
    end else if (acc_q[ITERS] < -LIM) begin
      ang_q <= -LIM;
    end else begin
      ang_q <= acc_q[ITERS];
    end
  end

  assign ang_o = ang_q;

endmodule
`default_nettype wire

// File: rtl/core/q2e_back.sv
`default_nettype none
module q2e_back #(
  parameter int BINS = q2e_pkg::BINS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pop_i,
  input  wire q2e_pkg::q2e_cmd_t    cmd_i,
  output logic                      valid_o,
  output q2e_pkg::q2e_result_t      result_o
);
  import q2e_pkg::*;

  localparam int VL = 2 + SQRT_LAT + CORDIC_LAT;
  localparam logic [BINS_MAX_W-1:0] BinsC = BINS_MAX_W'(BINS);
  localparam int UF_W = ANG_W - 1;
  localparam int UP_W = ANG_W - 2;

  logic [VL-1:0]        vld_q;
  logic                 valid_q;
  q2e_cmd_t             cmd0_q, cmd1_q;
  q2e_cmd_t             sdl_q [SQRT_LAT];
  logic                 pfull_q [CORDIC_LAT];
  logic                 psign_q [CORDIC_LAT];
  logic [SQ_IN_W-1:0]   sqin_q;
  logic [2*S_W-1:0]     sq;
  logic [RT_W-1:0]      root;
  q2e_cmd_t             sd;
  ang_t                 roll_a, yaw_a, pitch_a, pitch_p, roll_s, yaw_s;
  logic [UF_W-1:0]      u_r, u_y;
  logic [UP_W-1:0]      u_p;
  logic [UF_W+BINS_MAX_W-1:0] prod_r, prod_y;
  logic [UP_W+BINS_MAX_W-1:0] prod_p;
  q2e_result_t          result_q;

  // Track items through the whole pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[VL-2:0], pop_i};
      valid_q <= vld_q[VL-1];
    end
  end

  // Take the popped item, then form the cosine radicand
  assign sq = (2*S_W)'(cmd0_q.pitch_s * cmd0_q.pitch_s);

  always_ff @(posedge clk_i) begin
    cmd0_q <= cmd_i;
    cmd1_q <= cmd0_q;
    sqin_q <= SQ_IN_W'((2*S_W)'(64'h1000_0000_0000_0000) - sq);
  end

  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .v_i    (sqin_q),
    .root_o (root)
  );

  // Hold the atan2 arguments alongside the root
  always_ff @(posedge clk_i) begin
    sdl_q[0] <= cmd1_q;
    for (int k = 1; k < SQRT_LAT; k++) begin
      sdl_q[k] <= sdl_q[k-1];
    end
  end

  assign sd = sdl_q[SQRT_LAT-1];

  q2e_cordic #(.LIM(ANG_LIM_FULL)) u_roll (
    .clk_i (clk_i),
    .y_i   (sd.roll_y),
    .x_i   (sd.roll_x),
    .ang_o (roll_a)
  );

  q2e_cordic #(.LIM(ANG_LIM_FULL)) u_yaw (
    .clk_i (clk_i),
    .y_i   (sd.yaw_y),
    .x_i   (sd.yaw_x),
    .ang_o (yaw_a)
  );

  q2e_cordic #(.LIM(ANG_LIM_HALF)) u_pitch (
    .clk_i (clk_i),
    .y_i   (ARG_W'(sd.pitch_s)),
    .x_i   (ARG_W'(root)),
    .ang_o (pitch_a)
  );

  // Hold the saturated-pitch flag across the rotation stages
  always_ff @(posedge clk_i) begin
    pfull_q[0] <= sd.pitch_full;
    psign_q[0] <= sd.pitch_s[S_W-1];
    for (int k = 1; k < CORDIC_LAT; k++) begin
      pfull_q[k] <= pfull_q[k-1];
      psign_q[k] <= psign_q[k-1];
    end
  end

  // Offset each angle to zero and scale to bins
  always_comb begin
    if (pfull_q[CORDIC_LAT-1]) begin
      pitch_p = psign_q[CORDIC_LAT-1] ? -ANG_QUARTER : ANG_QUARTER;
    end else begin
      pitch_p = pitch_a;
    end
    roll_s = roll_a + ANG_HALF;
    yaw_s  = yaw_a + ANG_HALF;
    u_r    = roll_s[UF_W-1:0];
    u_y    = yaw_s[UF_W-1:0];
    u_p    = UP_W'(pitch_p + ANG_QUARTER);
    prod_r = (UF_W+BINS_MAX_W)'(u_r) * (UF_W+BINS_MAX_W)'(BinsC);
    prod_y = (UF_W+BINS_MAX_W)'(u_y) * (UF_W+BINS_MAX_W)'(BinsC);
    prod_p = (UP_W+BINS_MAX_W)'(u_p) * (UP_W+BINS_MAX_W)'(BinsC);
  end

  always_ff @(posedge clk_i) begin
    result_q.roll_bin  <= prod_r[UF_W-1 +: BIN_W];
    result_q.yaw_bin   <= prod_y[UF_W-1 +: BIN_W];
    result_q.pitch_bin <= prod_p[UP_W-1 +: BIN_W];
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

// File: rtl/core/quaternion_to_euler_bins_core.sv
`default_nettype none
// Quaternion to Euler-angle bins. One quaternion (w, x, y, z, signed Q1.15)
// enters per clock when start is high and busy is low; its roll, pitch and
// yaw bin indices (0..BINS) appear on result_o for one cycle under
// result_valid_o, in input order. The path is fully pipelined: one product
// stage, a four-entry command queue, a 31-stage square root for the pitch
// cosine, 30 CORDIC stages and a scaling stage, so the sustained rate is
// one item per clock. The result side has no back-pressure; busy rises
// only if the queue ever fills, which does not happen while the pipeline
// drains one item each cycle.
module quaternion_to_euler_bins_core #(
  parameter int BINS = q2e_pkg::BINS_DEFAULT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire q2e_pkg::q2e_quat_t     quat_i,
  output logic                        result_valid_o,
  output q2e_pkg::q2e_result_t        result_o
);
  import q2e_pkg::*;

  logic       accept, push, pop;
  q2e_cmd_t   push_cmd, pop_cmd;
  q2e_qstat_t qstat;

  // Hold off new items when the queue could overflow
  assign busy   = ((QLVL_W+1)'(qstat.level) + (QLVL_W+1)'(push)) >= (QLVL_W+1)'(QDEPTH);
  assign accept = start && !busy;
  assign pop    = !qstat.empty;

  q2e_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .quat_i  (quat_i),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  q2e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (pop_cmd),
    .stat_o (qstat)
  );

  q2e_back #(.BINS(BINS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pop_i    (pop),
    .cmd_i    (pop_cmd),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.level <= QLVL_W'(QDEPTH))
    else $error("queue level beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && qstat.level == QLVL_W'(QDEPTH)))
    else $error("push into full queue");

  a_accept_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> push)
    else $error("accepted item lost before queue");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (BINS > 31) ||
      (result_o.roll_bin <= BINS && result_o.pitch_bin <= BINS &&
       result_o.yaw_bin <= BINS))
    else $error("bin index beyond bin count");

endmodule
`default_nettype wire
